/* rtl/uer_pkg.sv */
package uer_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TLOW,
    PH_THIGH,
    PH_WAIT,
    PH_MEAS
  } phase_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_TRIG_LOW  = 2'd1,
    REG_TRIG_HIGH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  trig_low_ticks;
    logic [7:0]  trig_high_ticks;
  } cfg_t;

  typedef struct packed {
    logic [13:0] last_distance_mm;
    logic [13:0] distance_mm;
    logic [15:0] pulse_ticks;
    logic        valid_res;
    logic        done_res;
    logic        busy_res;
    logic        trig;
  } res_t;

  localparam logic [15:0] TIMEOUT_RST   = 16'd60000;
  localparam logic [7:0]  TRIG_LOW_RST  = 8'd2;
  localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [15:0] PULSE_MAX   = 16'hFFFF;
  localparam logic [13:0] DIST_MAX    = 14'h3FFF;

  // distance = (pulse * DIST_MUL + DIST_ROUND) / DIST_DIV, tracked as quotient/remainder
  localparam int unsigned DIST_MUL   = 1715;
  localparam int unsigned DIST_ROUND = 5000;
  localparam int unsigned DIST_DIV   = 10000;
  localparam logic [13:0] DIST_Q0    = 14'((DIST_MUL + DIST_ROUND) / DIST_DIV);
  localparam logic [13:0] DIST_R0    = 14'((DIST_MUL + DIST_ROUND) % DIST_DIV);

endpackage

/* rtl/uer_ctrl.sv */
module uer_ctrl import uer_pkg::*; #(
  parameter int unsigned COUNT_MAX = 65535
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic start_req,
  input  logic echo,
  input  cfg_t cfg,
  output res_t res
);

  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam logic [CW-1:0] WC_MAX = CW'(COUNT_MAX);

  phase_t      phase, phase_next;
  logic [7:0]  phase_ticks, phase_ticks_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [CW-1:0] width_count, width_count_next;
  logic [13:0] dist_q, dist_q_next;
  logic [13:0] dist_r, dist_r_next;
  logic        prev_echo;
  logic [13:0] held_distance, held_distance_next;

  phase_t      ph0;
  logic [7:0]  pt0, pt_inc;
  logic [15:0] el0;
  logic        go, rise, fall, fin_ok, tmo;
  logic [13:0] r_sum;

  assign go   = (phase == PH_IDLE) && start_req;
  assign rise = echo && !prev_echo;
  assign fall = !echo && prev_echo;
  assign ph0  = go ? ((cfg.trig_low_ticks != 8'd0) ? PH_TLOW : PH_THIGH) : phase;
  assign pt0  = go ? 8'd0 : phase_ticks;
  assign el0  = go ? 16'd0 : elapsed_ticks;
  assign pt_inc = pt0 + 8'd1;
  assign fin_ok = (ph0 == PH_MEAS) && fall;
  // timeout only when the echo did not finish on this tick
  assign tmo    = (ph0 != PH_IDLE) && !fin_ok && (el0 >= cfg.timeout_ticks);
  assign r_sum  = dist_r + 14'(DIST_MUL);

  // next phase
  always_comb begin
    phase_next = ph0;
    case (ph0)
      PH_TLOW:  if (pt_inc >= cfg.trig_low_ticks) phase_next = PH_THIGH;
      PH_THIGH: if (pt_inc >= cfg.trig_high_ticks) phase_next = PH_WAIT;
      PH_WAIT:  if (rise) phase_next = PH_MEAS;
      PH_MEAS:  if (fall) phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
    if (tmo) phase_next = PH_IDLE;
  end

  // counters and result
  always_comb begin
    phase_ticks_next   = pt0;
    elapsed_ticks_next = el0;
    width_count_next   = width_count;
    dist_q_next        = dist_q;
    dist_r_next        = dist_r;
    held_distance_next = held_distance;
    res                = '0;

    case (ph0)
      PH_TLOW: begin
        phase_ticks_next = (pt_inc >= cfg.trig_low_ticks) ? 8'd0 : pt_inc;
      end
      PH_THIGH: begin
        res.trig = 1'b1;
        phase_ticks_next = (pt_inc >= cfg.trig_high_ticks) ? 8'd0 : pt_inc;
      end
      PH_WAIT: begin
        if (rise) begin
          width_count_next = CW'(1);
          dist_q_next      = DIST_Q0;
          dist_r_next      = DIST_R0;
        end
      end
      PH_MEAS: begin
        if (fall) begin
          res.valid_res      = 1'b1;
          res.pulse_ticks    = (32'(width_count) > 32'(PULSE_MAX)) ? PULSE_MAX
                                                                    : 16'(width_count);
          res.distance_mm    = dist_q;
          held_distance_next = dist_q;
        end else if (width_count < WC_MAX) begin
          width_count_next = width_count + CW'(1);
          if (32'(r_sum) >= DIST_DIV) begin
            dist_r_next = r_sum - 14'(DIST_DIV);
            dist_q_next = (dist_q == DIST_MAX) ? dist_q : dist_q + 14'd1;
          end else begin
            dist_r_next = r_sum;
          end
        end
      end
      default: ;
    endcase

    if (ph0 != PH_IDLE && !fin_ok && !tmo && el0 < ELAPSED_MAX) begin
      elapsed_ticks_next = el0 + 16'd1;
    end

    res.done_res         = fin_ok || tmo;
    res.busy_res         = (phase_next != PH_IDLE);
    res.last_distance_mm = held_distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_ticks   <= '0;
      elapsed_ticks <= '0;
      width_count   <= '0;
      dist_q        <= '0;
      dist_r        <= '0;
      prev_echo     <= 1'b0;
      held_distance <= '0;
    end else if (step) begin
      phase         <= phase_next;
      phase_ticks   <= phase_ticks_next;
      elapsed_ticks <= elapsed_ticks_next;
      width_count   <= width_count_next;
      dist_q        <= dist_q_next;
      dist_r        <= dist_r_next;
      prev_echo     <= echo;
      held_distance <= held_distance_next;
    end
  end

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger: one input word per microsecond tick, one result word per input.
// Input acceptance to result valid passes the input register, then the result register.
// Throughput: one word per cycle unless m_tready stalls; the counters and the remainder
// tracker mod 10000 update once per tick, so no multiplier or divider sits in the path.
// Reset (rst, synchronous, active high): idle phase, counters and held distance cleared,
// registers back to timeout 60000, trigger low 2, trigger high 10; both stages empty.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int unsigned COUNT_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] start_req, [1] echo, [7:2] to be driven zero, not checked
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [0] trig, [1] busy_res, [2] done_res, [3] valid_res,
                                 // [19:4] pulse_ticks, [33:20] distance_mm,
                                 // [47:34] last_distance_mm
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;
  res_t res;

  // input stage
  logic a_valid;
  logic a_start;
  logic a_echo;
  logic step;

  // the staged word moves on when the result register is free or being drained
  assign step     = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_start <= s_tdata[0];
      a_echo  <= s_tdata[1];
    end
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks   <= TIMEOUT_RST;
      cfg.trig_low_ticks  <= TRIG_LOW_RST;
      cfg.trig_high_ticks <= TRIG_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT:   cfg.timeout_ticks   <= cfg_data;
        REG_TRIG_LOW:  cfg.trig_low_ticks  <= cfg_data[7:0];
        REG_TRIG_HIGH: cfg.trig_high_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // measurement sequencer: trigger, echo wait, width count, timeout
  uer_ctrl #(
    .COUNT_MAX(COUNT_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .start_req (a_start),
    .echo      (a_echo),
    .cfg       (cfg),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= res;
    end
  end

endmodule
